// ===== hdl/mexp_pkg.sv =====
package mexp_pkg;

   // Width of every field and configuration register on the ports
   localparam int FIELD_BITS = 16;

   // Configuration register index width (two registers)
   localparam int CSR_INDEX_BITS = 1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 1'b1;

   // Status of the bit-serial modular multiplier towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mexp_mul_status_type;

endpackage

// ===== hdl/mexp_req_if.sv =====
interface mexp_req_if import mexp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] message;

   modport source (output valid, output message, input ready);
   modport sink   (input valid, input message, output ready);
endinterface

// ===== hdl/mexp_rsp_if.sv =====
interface mexp_rsp_if import mexp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

// ===== hdl/modular_exponentiation_core.sv =====
// Channel  | Direction | Payload              | Transaction
// req_bus  | in        | message [15:0]       | valid & ready high at a rising edge
// rsp_bus  | out       | power_result [15:0]  | valid & ready high at a rising edge
// csr_*    | in        | csr_write_data[15:0] | csr_write_enable high at a rising edge
//
// One transaction at a time. Each modular multiply holds the bit-serial multiplier until
// it has stepped through every multiplier bit and reported completion. After the request
// transaction the core reduces the message, then walks the exponent, multiplying on each
// one bit and squaring on every bit; req_bus is ready again once the result is loaded
// into the output register. Zero exponent or modulus below two: no multiply is run and
// the sequencer goes straight to finish with result 1 (zero exponent wins) or 0.
// Reset (synchronous, active high) sets exponent to 1 and modulus to 2.
// A result waiting on rsp_bus does not block the next request transaction; the next
// result then waits in finish until the output register is free.
module modular_exponentiation_core import mexp_pkg::*; #(
   parameter int MOD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_write_data,
   mexp_req_if.sink                  req_bus,
   mexp_rsp_if.source                rsp_bus
);

   localparam int W     = MOD_BITS;
   localparam int WideW = (W > FIELD_BITS) ? W : FIELD_BITS;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_STEP   = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [FIELD_BITS-1:0]  exponent_ff, exponent_in;
   logic [FIELD_BITS-1:0]  modulus_ff, modulus_in;
   logic [FIELD_BITS-1:0]  exp_ff, exp_in;
   logic [W-1:0]           mod_ff, mod_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic [W-1:0]           base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]  rsp_data_ff, rsp_data_in;

   logic [WideW-1:0]       msg_wide;
   logic [WideW-1:0]       mod_wide;
   logic [WideW-1:0]       acc_wide;
   logic [W-1:0]           msg_w;
   logic [W-1:0]           mod_w;

   logic                   mul_start;
   logic [W-1:0]           mul_a;
   logic [W-1:0]           mul_b;
   logic [W-1:0]           mul_product;
   mexp_mul_status_type    mul_status;

   // Keep only the low MOD_BITS bits of message and modulus
   assign msg_wide = WideW'(req_bus.message);
   assign mod_wide = WideW'(modulus_ff);
   assign acc_wide = WideW'(acc_ff);
   assign msg_w    = msg_wide[W-1:0];
   assign mod_w    = mod_wide[W-1:0];

   // Configuration registers: write only; the user must write them only while idle, the block does not enforce it
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPONENT: exponent_in = csr_write_data;
            CSR_MODULUS:  modulus_in  = csr_write_data;
            default: begin
               exponent_in = exponent_ff;
            end
         endcase
      end
   end

   // Sequencer: unless the exponent is zero or the modulus below two, reduce the message, then
   // walk the exponent LSB first, multiplying into the accumulator on a one and squaring the base each bit.
   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_a        = acc_ff;
      mul_b        = base_ff;

      // Drop the held result once the sink takes it
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               exp_in = exponent_ff;
               mod_in = mod_w;
               if (exponent_ff == '0) begin
                  acc_in   = W'(1);
                  state_in = ST_FINISH;
               end else if (mod_w < W'(2)) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  // message mod m, formed as 1 * message through the multiplier
                  mul_start = 1'b1;
                  mul_a     = W'(1);
                  mul_b     = msg_w;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_status.done) begin
               base_in  = mul_product;
               acc_in   = W'(1);
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = base_ff;
               state_in  = ST_MULT;
            end else begin
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_status.done) begin
               acc_in    = mul_product;
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_status.done) begin
               base_in  = mul_product;
               exp_in   = exp_ff >> 1;
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_wide[FIELD_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   mexp_mulmod #(
      .W (W)
   ) u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .modulus   (mod_in),
      .status    (mul_status),
      .product   (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exponent_ff  <= FIELD_BITS'(1);
         modulus_ff   <= FIELD_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.power_result = rsp_data_ff;

`ifndef ASSERT_OFF
   // The multiplier reports completion only to a state that waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |-> (state_ff == ST_REDUCE || state_ff == ST_MULT ||
                           state_ff == ST_SQUARE))
      else $error("multiplier done outside a multiply state");

   // A pending exponent bit always launches a multiply
   a_step_launches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && exp_ff != '0) |=> mul_status.busy)
      else $error("exponent step did not start the multiplier");

   // The accumulator stays reduced once the exponent is used up
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && exp_ff == '0) |-> (acc_ff < mod_ff))
      else $error("accumulator not below modulus");

   // A finished result is loaded into the output register when it leaves
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("result lost on leaving finish");
`endif

endmodule

// ===== hdl/mexp_mulmod.sv =====
module mexp_mulmod import mexp_pkg::*; #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [W-1:0]        operand_a,
   input  logic [W-1:0]        operand_b,
   input  logic [W-1:0]        modulus,
   output mexp_mul_status_type status,
   output logic [W-1:0]        product
);

   localparam int CntW = $clog2(W + 1);
   localparam int TW   = W + 2;

   logic [W-1:0]        a_ff, a_in;
   logic [W-1:0]        b_ff, b_in;
   logic [W-1:0]        m_ff, m_in;
   logic [W-1:0]        r_ff, r_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   mexp_mul_status_type status_ff, status_in;

   logic [TW-1:0] sum;
   logic [TW-1:0] m_once;
   logic [TW-1:0] m_twice;
   logic [W-1:0]  r_step;

   // One multiplier bit per cycle, MSB first: r = 2r + bit*a, folded below m.
   // With r < m and a < m the sum stays below 3m.
   always_comb begin
      sum     = TW'({r_ff, 1'b0}) + (b_ff[W-1] ? TW'(a_ff) : TW'(0));
      m_once  = TW'(m_ff);
      m_twice = TW'({m_ff, 1'b0});
      if (sum >= m_twice) begin
         r_step = W'(sum - m_twice);
      end else if (sum >= m_once) begin
         r_step = W'(sum - m_once);
      end else begin
         r_step = W'(sum);
      end
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      m_in      = m_ff;
      r_in      = r_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      status_in.done = 1'b0;
      if (start) begin
         a_in           = operand_a;
         b_in           = operand_b;
         m_in           = modulus;
         r_in           = '0;
         cnt_in         = CntW'(W);
         status_in.busy = 1'b1;
      end else if (status_ff.busy) begin
         r_in   = r_step;
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            status_in.busy = 1'b0;
            status_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign status  = status_ff;
   assign product = r_ff;

endmodule
